// ----- hdl/fwrfs_pkg.sv -----
`default_nettype none

package fwrfs_pkg;

    // Block sizes.
    localparam int MAX_FIELDS  = 8;
    localparam int LINE_MAX    = 256;
    localparam int FIELD_IDX_W = $clog2(MAX_FIELDS);
    localparam int COUNT_W     = 4;
    localparam int POS_W       = 9;
    localparam int ROW_W       = 16;
    localparam int STARTS_W    = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    // Characters that steer the parser.
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_STARTS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT_RD,
        S_HIT_WR,
        S_CHK_RD,
        S_CHK_EVAL,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_IDX_W-1:0] field_index;
        logic [7:0]             field_offset;
        logic [8:0]             field_length;
        logic [ROW_W-1:0]       line_number;
        logic                   last_field;
    } t_out_beat;

    // Per-field state held in the field memory.
    typedef struct packed {
        logic             bad;
        logic [POS_W-1:0] trimmed_end;
    } t_entry;

    // Start offset of one field from the packed start register.
    function automatic logic [7:0] start_of(input logic [STARTS_W-1:0] starts,
                                            input logic [FIELD_IDX_W-1:0] idx);
        return starts[{idx, 3'b000} +: 8];
    endfunction

    // Field count clamped to 1..MAX_FIELDS.
    function automatic logic [COUNT_W-1:0] active_fields(input logic [COUNT_W-1:0] fc);
        logic [COUNT_W-1:0] n;
        n = fc;
        if (n == '0) n = COUNT_W'(1);
        if (n > COUNT_W'(MAX_FIELDS)) n = COUNT_W'(MAX_FIELDS);
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/fwrfs_in_if.sv -----
`default_nettype none

interface fwrfs_in_if;
    import fwrfs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

`default_nettype wire

// ----- hdl/fwrfs_out_if.sv -----
`default_nettype none

interface fwrfs_out_if;
    import fwrfs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

`default_nettype wire

// ----- hdl/fixed_width_record_field_splitter.sv -----
`default_nettype none

// Fixed-position record field splitter.
// Input channel i_in carries one beat per stream byte, or an end-of-file beat
// that carries no byte. CR and LF close the current line; runs of them are
// skipped. Output channel o_out carries one beat per field of an accepted
// line: field index, start offset, trimmed length, line number and a flag on
// the last field. Rejected lines produce no beats but still count as lines.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// Sequencing: per-field state lives in an 8-entry memory that is read,
// modified and written back. A data byte is taken in S_IDLE, then each field
// it lands in is read (S_HIT_RD) and written back (S_HIT_WR). A line end that
// is empty or rejected early is handled in S_IDLE; otherwise a check pass
// reads and tests each field (S_CHK_RD, S_CHK_EVAL), stopping at a bad one,
// and a report pass reads and emits each field (S_EMIT_RD, S_EMIT_LD).
// The last beat of a line sits in the output register, so the next input
// beat is taken while it waits. When the receiver stalls, the report pass
// holds and no input beat is accepted until the line is fully reported.
// Reset (synchronous, active low) clears the line state, the line counter
// and the output valid flag, and sets one field starting at offset 0.

module fixed_width_record_field_splitter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fwrfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fwrfs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    fwrfs_in_if.sink                                i_in,
    fwrfs_out_if.source                             o_out
);
    import fwrfs_pkg::*;

    localparam int ENTRY_W = $bits(t_entry);

    // Configuration registers.
    logic [COUNT_W-1:0]     r_field_count;
    logic [STARTS_W-1:0]    r_field_starts;

    // Control and line state.
    t_state                 r_state, n_state;
    logic [POS_W-1:0]       r_line_off;
    logic                   r_too_long;
    logic [MAX_FIELDS-1:0]  r_valid;
    logic [ROW_W-1:0]       r_row;
    logic [ROW_W-1:0]       r_line_num;
    logic [MAX_FIELDS-1:0]  r_mask;
    logic [7:0]             r_byte;
    logic [POS_W-1:0]       r_pos;
    logic [FIELD_IDX_W-1:0] r_addr;
    logic [FIELD_IDX_W-1:0] r_idx;
    logic                   r_out_valid;
    t_out_beat              r_out;

    // Combinational signals.
    logic [COUNT_W-1:0]     n_fields;
    logic [FIELD_IDX_W-1:0] last_idx;
    logic [7:0]             last_start;
    logic                   in_fire;
    logic                   is_eol;
    logic                   line_nonempty;
    logic                   line_ok_pre;
    logic [ROW_W-1:0]       row_inc;
    logic [MAX_FIELDS-1:0]  hit_mask;
    logic [MAX_FIELDS-1:0]  mask_rest;
    logic [FIELD_IDX_W-1:0] sel_idx;
    t_entry                 rd_entry;
    t_entry                 mod_entry;
    logic                   entry_fail;
    logic                   out_free;
    logic [7:0]             emit_start;

    // Memory port controls.
    logic                   ram_re;
    logic [FIELD_IDX_W-1:0] ram_raddr;
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic                   out_load;
    logic                   line_clear;

    fwrfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_FIELDS)
    ) u_field_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (mod_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Field geometry from the live configuration.
    assign n_fields   = active_fields(r_field_count);
    assign last_idx   = FIELD_IDX_W'(n_fields - COUNT_W'(1));
    assign last_start = start_of(r_field_starts, last_idx);

    // Input decode.
    assign i_in.ready    = (r_state == S_IDLE);
    assign in_fire       = i_in.valid & i_in.ready;
    assign is_eol        = i_in.beat.end_of_file || (i_in.beat.data_byte == CHAR_CR) ||
                           (i_in.beat.data_byte == CHAR_LF);
    assign line_nonempty = (r_line_off != '0) || r_too_long;
    assign line_ok_pre   = !r_too_long && (r_line_off > {1'b0, last_start});
    assign row_inc       = (r_row != '1) ? (r_row + ROW_W'(1)) : r_row;

    // Fields that the byte at the current offset belongs to.
    always_comb begin
        for (int i = 0; i < MAX_FIELDS; i++) begin
            hit_mask[i] = (COUNT_W'(i) < n_fields) &&
                          (r_line_off >= {1'b0, start_of(r_field_starts, FIELD_IDX_W'(i))}) &&
                          ((COUNT_W'(i) + COUNT_W'(1) >= n_fields) ||
                           (r_line_off <
                            {1'b0, start_of(r_field_starts, FIELD_IDX_W'(i + 1))}));
        end
    end

    // Lowest pending field of the byte being applied.
    always_comb begin
        sel_idx = '0;
        for (int i = MAX_FIELDS - 1; i >= 0; i--) begin
            if (r_mask[i]) sel_idx = FIELD_IDX_W'(i);
        end
    end

    assign mask_rest = r_mask & ~(MAX_FIELDS'(1) << r_addr);

    // An entry never written since the line began reads as cleared.
    assign rd_entry   = r_valid[r_addr] ? t_entry'(ram_rdata) : '0;
    assign entry_fail = rd_entry.bad || (rd_entry.trimmed_end == '0);

    // Read-modify-write of one field for the held byte.
    always_comb begin
        mod_entry = rd_entry;
        if (r_byte != CHAR_SPACE) begin
            mod_entry.trimmed_end = r_pos + POS_W'(1);
        end else if (r_pos == {1'b0, start_of(r_field_starts, r_addr)}) begin
            mod_entry.bad = 1'b1;
        end
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign emit_start = start_of(r_field_starts, r_idx);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (is_eol) begin
                        if (line_nonempty && line_ok_pre) n_state = S_CHK_RD;
                    end else if (!r_too_long && (r_line_off < POS_W'(LINE_MAX)) &&
                                 (hit_mask != '0)) begin
                        n_state = S_HIT_RD;
                    end
                end
            end
            S_HIT_RD:   n_state = S_HIT_WR;
            S_HIT_WR:   n_state = (mask_rest != '0) ? S_HIT_RD : S_IDLE;
            S_CHK_RD:   n_state = S_CHK_EVAL;
            S_CHK_EVAL: begin
                if (entry_fail)             n_state = S_IDLE;
                else if (r_idx == last_idx) n_state = S_EMIT_RD;
                else                        n_state = S_CHK_RD;
            end
            S_EMIT_RD:  n_state = S_EMIT_LD;
            S_EMIT_LD: begin
                if (out_free) n_state = (r_idx == last_idx) ? S_IDLE : S_EMIT_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb begin
        ram_re     = 1'b0;
        ram_raddr  = r_idx;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        line_clear = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                line_clear = in_fire && is_eol && !(line_nonempty && line_ok_pre);
            end
            S_HIT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = sel_idx;
            end
            S_HIT_WR: begin
                ram_we = 1'b1;
            end
            S_CHK_RD: begin
                ram_re = 1'b1;
            end
            S_CHK_EVAL: begin
                line_clear = entry_fail;
            end
            S_EMIT_RD: begin
                ram_re = 1'b1;
            end
            S_EMIT_LD: begin
                out_load   = out_free;
                line_clear = out_free && (r_idx == last_idx);
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.field_index  <= r_idx;
            r_out.field_offset <= emit_start;
            r_out.field_length <= rd_entry.trimmed_end - {1'b0, emit_start};
            r_out.line_number  <= r_line_num;
            r_out.last_field   <= (r_idx == last_idx);
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_addr <= ram_raddr;
        end
        if (in_fire && !is_eol) begin
            r_byte <= i_in.beat.data_byte;
            r_pos  <= r_line_off;
        end
        if (ram_we) begin
            r_mask <= mask_rest;
        end else if (in_fire && !is_eol) begin
            r_mask <= hit_mask;
        end
        if (in_fire && is_eol && line_nonempty) begin
            r_line_num <= row_inc;
        end
        if (in_fire) begin
            r_idx <= '0;
        end else if ((r_state == S_CHK_EVAL) && !entry_fail) begin
            r_idx <= (r_idx == last_idx) ? '0 : (r_idx + FIELD_IDX_W'(1));
        end else if (out_load) begin
            r_idx <= r_idx + FIELD_IDX_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_field_count  <= COUNT_W'(1);
            r_field_starts <= '0;
            r_line_off     <= '0;
            r_too_long     <= 1'b0;
            r_valid        <= '0;
            r_row          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FIELD_COUNT:  r_field_count  <= i_cfg_data[COUNT_W-1:0];
                    CFG_FIELD_STARTS: r_field_starts <= i_cfg_data[STARTS_W-1:0];
                    default:          r_field_count  <= r_field_count;
                endcase
            end

            // Line counting at a line end; end of file restarts numbering.
            if (in_fire && is_eol) begin
                if (i_in.beat.end_of_file) r_row <= '0;
                else if (line_nonempty)    r_row <= row_inc;
            end

            // Byte position and overlong detection.
            if (in_fire && !is_eol && !r_too_long) begin
                if (r_line_off >= POS_W'(LINE_MAX)) r_too_long <= 1'b1;
                else                                r_line_off <= r_line_off + POS_W'(1);
            end

            if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end

            // Output register handshake.
            if (out_load)         r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;

            // Start a fresh line.
            if (line_clear) begin
                r_line_off <= '0;
                r_too_long <= 1'b0;
                r_valid    <= '0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.beat  = r_out;

endmodule

`default_nettype wire

// ----- hdl/fwrfs_ram.sv -----
`default_nettype none

module fwrfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read data holds without a read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/fwrfs_field_checker.sv -----
`default_nettype none

// Watches the configuration port and both channels of the field splitter,
// predicts the field reports of every closed line and compares them, in order,
// with the beats that leave the block.
module fwrfs_field_checker
    import fwrfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_beat              i_in_beat,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_beat             i_out_beat,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_predicted
);

    // Printing stops after this many mismatches; counting goes on.
    localparam int PRINT_CAP = 40;

    // Register copies.
    logic [COUNT_W-1:0]  fields_reg;
    logic [STARTS_W-1:0] starts_reg;

    // Line state.
    int unsigned         line_len;
    bit                  overlong;
    int unsigned         trim_end [MAX_FIELDS];
    bit                  lead_space [MAX_FIELDS];
    logic [ROW_W-1:0]    line_count;

    // Field reports still owed by the block, oldest first.
    t_out_beat           owed_reports [$];

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_predicted = 0;
    end

    task automatic report(input string text);
        if (o_errors < PRINT_CAP)
            $display("[%0t] field report mismatch: %s", $time, text);
        o_errors++;
    endtask

    // Number of fields in use: zero counts as one, large values clamp.
    function automatic int unsigned fields_in_use();
        int unsigned n;
        n = fields_reg;
        if (n == 0)
            n = 1;
        else if (n > MAX_FIELDS)
            n = MAX_FIELDS;
        return n;
    endfunction

    function automatic int unsigned field_start(input int unsigned i);
        return starts_reg[8*i +: 8];
    endfunction

    task automatic clear_line();
        line_len = 0;
        overlong = 1'b0;
        for (int i = 0; i < MAX_FIELDS; i++) begin
            trim_end[i]   = 0;
            lead_space[i] = 1'b0;
        end
    endtask

    // A data byte lands in every field whose extent covers the current offset.
    task automatic scan_byte(input logic [7:0] b);
        int unsigned n;
        int unsigned p;
        int unsigned s;
        n = fields_in_use();
        p = line_len;
        if (overlong)
            return;
        if (p >= LINE_MAX) begin
            overlong = 1'b1;
            return;
        end
        for (int unsigned i = 0; i < n; i++) begin
            s = field_start(i);
            if (p >= s && !(i + 1 < n && p >= field_start(i + 1))) begin
                if (p == s && b == CHAR_SPACE)
                    lead_space[i] = 1'b1;
                if (b != CHAR_SPACE)
                    trim_end[i] = p + 1;
            end
        end
        line_len = p + 1;
    endtask

    // A non-empty line counts; an acceptable one owes one report per field.
    task automatic close_line();
        int unsigned n;
        bit          keep;
        t_out_beat   r;
        n = fields_in_use();
        if (line_len == 0 && !overlong)
            return;
        if (line_count != '1)
            line_count++;
        keep = !overlong && line_len > field_start(n - 1);
        for (int unsigned i = 0; i < n; i++)
            if (lead_space[i] || trim_end[i] == 0)
                keep = 1'b0;
        if (keep) begin
            for (int unsigned i = 0; i < n; i++) begin
                r.field_index  = FIELD_IDX_W'(i);
                r.field_offset = 8'(field_start(i));
                r.field_length = 9'(trim_end[i] - field_start(i));
                r.line_number  = line_count;
                r.last_field   = (i == n - 1);
                owed_reports.push_back(r);
                o_predicted++;
            end
        end
        clear_line();
    endtask

    // All traffic is sampled at the rising edge.
    always @(posedge i_clk) begin : track
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            fields_reg = COUNT_W'(1);
            starts_reg = '0;
            line_count = '0;
            clear_line();
            owed_reports.delete();
        end else begin
            // Outgoing beat against the oldest owed report.
            if (i_out_valid && i_out_ready) begin
                got = i_out_beat;
                if (owed_reports.size() == 0) begin
                    report($sformatf("beat with nothing owed: index %0d offset %0d length %0d",
                                     got.field_index, got.field_offset, got.field_length));
                end else begin
                    want = owed_reports.pop_front();
                    if (got.field_index !== want.field_index)
                        report($sformatf("field_index %0d, expected %0d",
                                         got.field_index, want.field_index));
                    if (got.field_offset !== want.field_offset)
                        report($sformatf("field_offset %0d, expected %0d",
                                         got.field_offset, want.field_offset));
                    if (got.field_length !== want.field_length)
                        report($sformatf("field_length %0d, expected %0d",
                                         got.field_length, want.field_length));
                    if (got.line_number !== want.line_number)
                        report($sformatf("line_number %0d, expected %0d",
                                         got.line_number, want.line_number));
                    if (got.last_field !== want.last_field)
                        report($sformatf("last_field %0d, expected %0d",
                                         got.last_field, want.last_field));
                end
            end

            // Register writes.
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIELD_COUNT)
                    fields_reg = i_cfg_data[COUNT_W-1:0];
                else if (i_cfg_index == CFG_FIELD_STARTS)
                    starts_reg = i_cfg_data[STARTS_W-1:0];
            end

            // Incoming beat.
            if (i_in_valid && i_in_ready) begin
                if (i_in_beat.end_of_file) begin
                    close_line();
                    line_count = '0;
                end else if (i_in_beat.data_byte == CHAR_CR || i_in_beat.data_byte == CHAR_LF) begin
                    close_line();
                end else begin
                    scan_byte(i_in_beat.data_byte);
                end
            end
        end
        o_pending = owed_reports.size();
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

// Drives byte streams into the field splitter and gives the verdict; the
// checker beside the block predicts and compares the field reports.
module testbench;
    import fwrfs_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fwrfs_in_if  in_ch ();
    fwrfs_out_if out_ch ();

    int errors;
    int pending;
    int predicted;

    // Pacing knobs; the idle and stall chances are in percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_cycles    = 0;

    int unsigned items_sent = 0;
    int unsigned cfg_writes = 0;

    // Copies of the registers, used to shape records.
    logic [COUNT_W-1:0]  cur_count  = COUNT_W'(1);
    logic [STARTS_W-1:0] cur_starts = '0;

    fixed_width_record_field_splitter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    fwrfs_field_checker field_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_beat   (in_ch.beat),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_beat  (out_ch.beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_predicted (predicted)
    );

    // Clock: period of 4.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                out_ch.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Safety net against a hung block.
    initial begin
        #400000;
        $display("timeout waiting for the block");
        $display("fixed_width_record_field_splitter regression: fail");
        $finish;
    end

    // Entered and left at a falling edge.
    task automatic send_beat(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.beat  <= '{data_byte: b, end_of_file: eof};
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // The input is held idle while a register is written.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        in_ch.valid <= 1'b0;
        cfg_we      <= 1'b1;
        cfg_index   <= idx;
        cfg_data    <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_FIELD_COUNT)
            cur_count = value[COUNT_W-1:0];
        else
            cur_starts = value[STARTS_W-1:0];
        cfg_writes++;
    endtask

    // Stop offering, wait for every owed report, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Any byte that is not a line end.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CHAR_CR || b == CHAR_LF)
            b = b ^ 8'h40;
        return b;
    endfunction

    // Line end: single CR or LF, a run of them, or end of file.
    task automatic end_line();
        case ($urandom_range(9))
            0: send_beat(8'($urandom_range(255)), 1'b1);
            1: begin
                send_beat(CHAR_CR, 1'b0);
                send_beat(CHAR_LF, 1'b0);
            end
            2: begin
                send_beat(CHAR_LF, 1'b0);
                send_beat(CHAR_LF, 1'b0);
                send_beat(CHAR_CR, 1'b0);
            end
            3, 4, 5: send_beat(CHAR_CR, 1'b0);
            default: send_beat(CHAR_LF, 1'b0);
        endcase
    endtask

    // A line of bytes with no spaces and no line ends.
    task automatic send_text(input int unsigned len);
        logic [7:0] b;
        for (int unsigned p = 0; p < len; p++) begin
            b = text_byte();
            if (b == CHAR_SPACE)
                b = "_";
            send_beat(b, 1'b0);
        end
    endtask

    // A shaped record fills every field and starts each with a non-space;
    // an unshaped one has random length and content.
    task automatic send_record(input bit shaped);
        int unsigned n;
        int unsigned last_start;
        int unsigned len;
        logic [7:0]  b;
        bit          at_start;
        n = cur_count;
        if (n == 0)
            n = 1;
        if (n > MAX_FIELDS)
            n = MAX_FIELDS;
        last_start = cur_starts[8*(n-1) +: 8];
        len = shaped ? last_start + $urandom_range(1, 5) : $urandom_range(0, last_start + 5);
        for (int unsigned p = 0; p < len; p++) begin
            at_start = 1'b0;
            for (int unsigned i = 0; i < n; i++)
                if (cur_starts[8*i +: 8] == p)
                    at_start = 1'b1;
            b = text_byte();
            if ($urandom_range(3) == 0)
                b = CHAR_SPACE;
            if (shaped && at_start && b == CHAR_SPACE)
                b = "#";
            send_beat(b, 1'b0);
        end
        end_line();
    endtask

    // Random layout with strictly increasing starts and a mix of counts.
    task automatic pick_layout();
        logic [STARTS_W-1:0] st;
        int unsigned         pos;
        logic [COUNT_W-1:0]  count;
        pos = $urandom_range(0, 3);
        for (int i = 0; i < MAX_FIELDS; i++) begin
            st[8*i +: 8] = 8'(pos);
            pos += $urandom_range(1, 4);
        end
        case ($urandom_range(7))
            0: count = '0;
            1: count = COUNT_W'($urandom_range(MAX_FIELDS + 1, 15));
            default: count = COUNT_W'($urandom_range(1, MAX_FIELDS));
        endcase
        write_reg(CFG_FIELD_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_FIELD_STARTS, st);
    endtask

    initial begin
        int unsigned base_items;
        int          base_reports;

        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.beat   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats under the reset layout: one field at offset 0.
        send_beat("A", 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CHAR_CR, 1'b0);
        send_beat(CHAR_LF, 1'b0);
        send_beat(CHAR_CR, 1'b0);
        // Field that begins with a space.
        send_beat(CHAR_SPACE, 1'b0);
        send_beat("x", 1'b0);
        send_beat(CHAR_LF, 1'b0);
        // Trailing spaces trimmed.
        send_beat("a", 1'b0);
        send_beat("b", 1'b0);
        send_beat(CHAR_SPACE, 1'b0);
        send_beat(CHAR_SPACE, 1'b0);
        send_beat(CHAR_CR, 1'b0);
        // End of file closes a partial line; its byte is ignored.
        send_beat(8'h7F, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);
        send_beat(CHAR_LF, 1'b0);
        send_beat("Z", 1'b0);
        send_beat(8'h00, 1'b1);
        drain();

        // Zero count acts as one field running the whole line.
        write_reg(CFG_FIELD_COUNT, '0);
        write_reg(CFG_FIELD_STARTS, '0);
        send_text(6);
        end_line();
        drain();
        // A line that stops at the start of its last field, then one past it.
        write_reg(CFG_FIELD_COUNT, CFG_DATA_W'(2));
        write_reg(CFG_FIELD_STARTS, CFG_DATA_W'(16'h0400));
        send_text(4);
        send_beat(CHAR_LF, 1'b0);
        send_text(5);
        send_beat(CHAR_CR, 1'b0);
        drain();
        // Largest count with two equal starts: the field between them is empty.
        write_reg(CFG_FIELD_COUNT, CFG_DATA_W'(15));
        write_reg(CFG_FIELD_STARTS, 64'h0706_0504_0303_0100);
        send_text(9);
        send_beat(CHAR_LF, 1'b0);
        send_beat(8'h00, 1'b1);
        drain();

        // Random records over the four pacing mixes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            pick_layout();
            if (ph == 0)
                hold_cycles = 300;
            base_items   = items_sent;
            base_reports = predicted;
            while (items_sent - base_items < 24 || predicted - base_reports < 3)
                send_record($urandom_range(9) < 8);
            send_beat(8'($urandom_range(255)), 1'b1);
            drain();
        end

        $display("Drove %0d input beats and %0d register writes; %0d field reports were checked.",
                 items_sent, cfg_writes, predicted);
        $display("Runs covered every kind of line end, bad and empty fields, odd field counts");
        $display("and four pacing mixes, one with a long receiver hold-off.");
        if (errors == 0 && pending == 0)
            $display("fixed_width_record_field_splitter regression: pass");
        else
            $display("fixed_width_record_field_splitter regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
